// ===== design/hut_pkg.sv =====
// ----------------------------------------------------------------------------
// hut_pkg: shared types and constants of the URL tokenizer
// Component and status codes, character constants, the command word passed
// from the front part to the back part, and the default-text tables.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hut_pkg;

    // Depth of the command queue between front and back.
    localparam int Q_DEPTH = 4;

    // Delimiter characters.
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    // Scheme prefix match: lengths of "http" and "https", and the mismatch mark.
    localparam logic [2:0] MATCH_HTTP  = 3'd4;
    localparam logic [2:0] MATCH_HTTPS = 3'd5;
    localparam logic [2:0] MATCH_BAD   = 3'd7;

    // Length of the default path text, minus one.
    localparam logic [3:0] PATH_LAST = 4'd9;

    typedef enum logic [2:0] {
        COMP_SCHEME = 3'd0,
        COMP_HOST   = 3'd1,
        COMP_PORT   = 3'd2,
        COMP_PATH   = 3'd3,
        COMP_PARAMS = 3'd4,
        COMP_STATUS = 3'd5
    } t_comp;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NO_COLON   = 3'd1,
        ST_BAD_SCHEME = 3'd2,
        ST_NO_SLASH   = 3'd3,
        ST_HOST_OPEN  = 3'd4,
        ST_NO_DOT     = 3'd5,
        ST_BARE_SLASH = 3'd6
    } t_status;

    // Which default port text the back part must emit.
    typedef enum logic [1:0] {
        PK_NONE = 2'd0,
        PK_80   = 2'd1,
        PK_443  = 2'd2
    } t_port_kind;

    // One command: an optional character, then optionally the URL close.
    typedef struct packed {
        logic       has_char;
        t_comp      comp;
        logic [7:0] sym;
        logic       fin;
        t_port_kind port_kind;
        logic       path_default;
        t_status    status;
    } t_cmd;

    // Characters of "https", by matched prefix length.
    function automatic logic [7:0] scheme_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h68;
            3'd1:    ch = 8'h74;
            3'd2:    ch = 8'h74;
            3'd3:    ch = 8'h70;
            default: ch = 8'h73;
        endcase
        return ch;
    endfunction

    // Characters of "index.html".
    function automatic logic [7:0] path_char(input logic [3:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0:    ch = 8'h69;
            4'd1:    ch = 8'h6E;
            4'd2:    ch = 8'h64;
            4'd3:    ch = 8'h65;
            4'd4:    ch = 8'h78;
            4'd5:    ch = 8'h2E;
            4'd6:    ch = 8'h68;
            4'd7:    ch = 8'h74;
            4'd8:    ch = 8'h6D;
            default: ch = 8'h6C;
        endcase
        return ch;
    endfunction

    // Characters of "80" or "443".
    function automatic logic [7:0] port_digit(input t_port_kind kind,
                                              input logic [1:0] idx);
        logic [7:0] ch;
        if (kind == PK_443) begin
            ch = (idx == 2'd2) ? 8'h33 : 8'h34;
        end else begin
            ch = (idx == 2'd0) ? 8'h38 : 8'h30;
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

// ===== design/hut_front.sv =====
// ----------------------------------------------------------------------------
// hut_front: character classifier of the URL tokenizer
// Tracks the URL phase, lowercases each character and turns it into one
// command word for the back part: an optional tagged character and the close.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hut_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [7:0]    i_symbol_in,
    input  wire logic          i_end_of_url,
    input  wire logic          i_q_ready,
    output logic               o_push,
    output hut_pkg::t_cmd      o_cmd
);

    typedef enum logic [11:0] {
        PH_SCHEME    = 12'b0000_0000_0001,
        PH_SLASH1    = 12'b0000_0000_0010,
        PH_SLASH2    = 12'b0000_0000_0100,
        PH_HOSTSKIP  = 12'b0000_0000_1000,
        PH_HOST      = 12'b0000_0001_0000,
        PH_PORT      = 12'b0000_0010_0000,
        PH_PATHFIRST = 12'b0000_0100_0000,
        PH_PATHSKIP  = 12'b0000_1000_0000,
        PH_PATH      = 12'b0001_0000_0000,
        PH_PARAMS    = 12'b0010_0000_0000,
        PH_ERROR     = 12'b0100_0000_0000,
        PH_DISCARD   = 12'b1000_0000_0000
    } t_phase;

    t_phase           r_phase, n_phase;
    logic [2:0]       r_match, n_match;
    logic             r_secure, n_secure;
    logic             r_dot, n_dot;
    logic             r_port, n_port;
    logic             r_path, n_path;
    logic             r_prev, n_prev;
    hut_pkg::t_status r_err, n_err;

    logic             accept;
    logic [7:0]       lc;
    logic             do_host;
    logic             do_path;
    logic             fin;
    hut_pkg::t_cmd    cmd;

    assign o_ready = i_q_ready;
    assign accept  = i_valid && i_q_ready;

    // Lowercase only the letters A to Z.
    always_comb begin
        lc = i_symbol_in;
        if (i_symbol_in >= hut_pkg::CH_UP_A && i_symbol_in <= hut_pkg::CH_UP_Z) begin
            lc = i_symbol_in + hut_pkg::CASE_OFS;
        end
    end

    // Phase tracking and command build for one accepted character.
    always_comb begin
        n_phase  = r_phase;
        n_match  = r_match;
        n_secure = r_secure;
        n_dot    = r_dot;
        n_port   = r_port;
        n_path   = r_path;
        n_prev   = r_prev;
        n_err    = r_err;
        do_host  = 1'b0;
        do_path  = 1'b0;
        fin      = 1'b0;
        cmd      = '0;

        if (accept && r_phase == PH_DISCARD) begin
            // Skip the tail after a newline; a new URL starts after the last byte.
            if (i_end_of_url) begin
                n_phase  = PH_SCHEME;
                n_match  = '0;
                n_secure = 1'b0;
                n_dot    = 1'b0;
                n_port   = 1'b0;
                n_path   = 1'b0;
                n_prev   = 1'b0;
                n_err    = hut_pkg::ST_OK;
            end
        end else if (accept) begin
            if (lc == hut_pkg::CH_NL) begin
                fin = 1'b1;
            end else begin
                unique case (r_phase)
                    PH_SCHEME: begin
                        if (lc == hut_pkg::CH_COLON) begin
                            if (r_match == hut_pkg::MATCH_HTTP) begin
                                n_secure = 1'b0;
                                n_phase  = PH_SLASH1;
                            end else if (r_match == hut_pkg::MATCH_HTTPS) begin
                                n_secure = 1'b1;
                                n_phase  = PH_SLASH1;
                            end else begin
                                n_err   = hut_pkg::ST_BAD_SCHEME;
                                n_phase = PH_ERROR;
                            end
                        end else begin
                            if (r_match < hut_pkg::MATCH_HTTPS
                                && hut_pkg::scheme_char(r_match) == lc) begin
                                n_match = r_match + 3'd1;
                            end else begin
                                n_match = hut_pkg::MATCH_BAD;
                            end
                            cmd.has_char = 1'b1;
                            cmd.comp     = hut_pkg::COMP_SCHEME;
                        end
                    end
                    PH_SLASH1: begin
                        if (lc == hut_pkg::CH_SLASH) begin
                            n_phase = PH_SLASH2;
                        end else begin
                            n_err   = hut_pkg::ST_NO_SLASH;
                            n_phase = PH_ERROR;
                        end
                    end
                    PH_SLASH2: begin
                        if (lc == hut_pkg::CH_SLASH) begin
                            n_phase = PH_HOSTSKIP;
                        end else begin
                            n_err   = hut_pkg::ST_NO_SLASH;
                            n_phase = PH_ERROR;
                        end
                    end
                    PH_HOSTSKIP: begin
                        do_host = (lc != hut_pkg::CH_SLASH);
                    end
                    PH_HOST: begin
                        do_host = 1'b1;
                    end
                    PH_PORT: begin
                        if (lc == hut_pkg::CH_SLASH) begin
                            n_phase = PH_PATHFIRST;
                        end else begin
                            cmd.has_char = 1'b1;
                            cmd.comp     = hut_pkg::COMP_PORT;
                        end
                    end
                    PH_PATHFIRST, PH_PATHSKIP: begin
                        if (lc == hut_pkg::CH_SLASH) begin
                            n_phase = PH_PATHSKIP;
                        end else begin
                            do_path = 1'b1;
                        end
                    end
                    PH_PATH: begin
                        do_path = 1'b1;
                    end
                    PH_PARAMS: begin
                        cmd.has_char = 1'b1;
                        cmd.comp     = hut_pkg::COMP_PARAMS;
                    end
                    PH_ERROR, PH_DISCARD: begin
                    end
                    default: begin
                    end
                endcase

                // Host characters end at a colon or a slash.
                if (do_host) begin
                    if (lc == hut_pkg::CH_COLON || lc == hut_pkg::CH_SLASH) begin
                        if (!r_dot) begin
                            n_err   = hut_pkg::ST_NO_DOT;
                            n_phase = PH_ERROR;
                        end else if (lc == hut_pkg::CH_COLON) begin
                            n_port  = 1'b1;
                            n_phase = PH_PORT;
                        end else begin
                            n_phase = PH_PATHFIRST;
                        end
                    end else begin
                        if (lc == hut_pkg::CH_DOT) begin
                            n_dot = 1'b1;
                        end
                        n_phase      = PH_HOST;
                        cmd.has_char = 1'b1;
                        cmd.comp     = hut_pkg::COMP_HOST;
                    end
                end

                // Path characters: a question mark opens the params, slashes collapse.
                if (do_path) begin
                    n_path = 1'b1;
                    if (lc == hut_pkg::CH_QMARK) begin
                        n_phase = PH_PARAMS;
                    end else begin
                        n_phase = PH_PATH;
                        if (lc == hut_pkg::CH_SLASH) begin
                            if (!r_prev) begin
                                cmd.has_char = 1'b1;
                                cmd.comp     = hut_pkg::COMP_PATH;
                            end
                            n_prev = 1'b1;
                        end else begin
                            n_prev       = 1'b0;
                            cmd.has_char = 1'b1;
                            cmd.comp     = hut_pkg::COMP_PATH;
                        end
                    end
                end

                fin = i_end_of_url;
            end

            cmd.sym = lc;

            // Close the URL: late errors, defaults and status, then a clean state.
            if (fin) begin
                if (n_phase == PH_SCHEME) begin
                    n_err = hut_pkg::ST_NO_COLON;
                end else if (n_phase == PH_SLASH1 || n_phase == PH_SLASH2) begin
                    n_err = hut_pkg::ST_NO_SLASH;
                end else if (n_phase == PH_HOSTSKIP || n_phase == PH_HOST) begin
                    n_err = hut_pkg::ST_HOST_OPEN;
                end else if (n_phase == PH_PATHFIRST) begin
                    n_err = hut_pkg::ST_BARE_SLASH;
                end
                cmd.fin    = 1'b1;
                cmd.status = n_err;
                if (n_err == hut_pkg::ST_OK && !n_port) begin
                    cmd.port_kind = n_secure ? hut_pkg::PK_443 : hut_pkg::PK_80;
                end else begin
                    cmd.port_kind = hut_pkg::PK_NONE;
                end
                cmd.path_default = (n_err == hut_pkg::ST_OK) && !n_path;

                n_phase  = (lc == hut_pkg::CH_NL && !i_end_of_url) ? PH_DISCARD : PH_SCHEME;
                n_match  = '0;
                n_secure = 1'b0;
                n_dot    = 1'b0;
                n_port   = 1'b0;
                n_path   = 1'b0;
                n_prev   = 1'b0;
                n_err    = hut_pkg::ST_OK;
            end
        end
    end

    // Phase and flag registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_SCHEME;
            r_match  <= '0;
            r_secure <= 1'b0;
            r_dot    <= 1'b0;
            r_port   <= 1'b0;
            r_path   <= 1'b0;
            r_prev   <= 1'b0;
            r_err    <= hut_pkg::ST_OK;
        end else begin
            r_phase  <= n_phase;
            r_match  <= n_match;
            r_secure <= n_secure;
            r_dot    <= n_dot;
            r_port   <= n_port;
            r_path   <= n_path;
            r_prev   <= n_prev;
            r_err    <= n_err;
        end
    end

    // Only commands that produce output are queued.
    assign o_push = accept && (cmd.has_char || cmd.fin);
    assign o_cmd  = cmd;

endmodule

`default_nettype wire

// ===== design/hut_queue.sv =====
// ----------------------------------------------------------------------------
// hut_queue: command queue between front and back
// A small register FIFO so that the front keeps taking characters while the
// back is still emitting the defaults of an earlier URL.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hut_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  hut_pkg::t_cmd      i_cmd,
    output logic               o_not_full,
    input  wire logic          i_pop,
    output logic               o_not_empty,
    output hut_pkg::t_cmd      o_cmd
);

    localparam int PtrW = $clog2(hut_pkg::Q_DEPTH);
    localparam int CntW = $clog2(hut_pkg::Q_DEPTH + 1);

    hut_pkg::t_cmd  r_mem [hut_pkg::Q_DEPTH];
    logic [PtrW-1:0] r_wr, r_rd;
    logic [CntW-1:0] r_cnt;
    logic            do_push, do_pop;

    assign o_not_full  = (r_cnt != CntW'(hut_pkg::Q_DEPTH));
    assign o_not_empty = (r_cnt != '0);
    assign do_push     = i_push && o_not_full;
    assign do_pop      = i_pop && o_not_empty;
    assign o_cmd       = r_mem[r_rd];

    // Storage; entries need no reset.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PtrW'(hut_pkg::Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PtrW'(hut_pkg::Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/hut_back.sv =====
// ----------------------------------------------------------------------------
// hut_back: result sequencer of the URL tokenizer
// Expands each command into result transactions: the character, the default
// port and path text, and the status item, one per cycle into an output register unless stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hut_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_not_empty,
    input  hut_pkg::t_cmd      i_q_cmd,
    output logic               o_q_pop,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [2:0]         o_component,
    output logic [7:0]         o_out_symbol,
    output logic               o_has_symbol,
    output logic [2:0]         o_status,
    output logic               o_final_item
);

    typedef enum logic [3:0] {
        S_CHAR = 4'b0001,
        S_PORT = 4'b0010,
        S_PATH = 4'b0100,
        S_STAT = 4'b1000
    } t_sub;

    hut_pkg::t_cmd r_cmd;
    logic          r_act;
    t_sub          r_sub, n_sub;
    logic [3:0]    r_idx, n_idx;
    logic          r_ovalid;

    logic          load;
    logic          last_item;
    logic [2:0]    cur_comp;
    logic [7:0]    cur_sym;
    logic          cur_has;
    logic [2:0]    cur_status;
    logic          cur_final;

    // First step of the close sequence of a command.
    function automatic t_sub fin_start(input hut_pkg::t_cmd c);
        t_sub s;
        if (c.port_kind != hut_pkg::PK_NONE) begin
            s = S_PORT;
        end else if (c.path_default) begin
            s = S_PATH;
        end else begin
            s = S_STAT;
        end
        return s;
    endfunction

    function automatic t_sub cmd_start(input hut_pkg::t_cmd c);
        return c.has_char ? S_CHAR : fin_start(c);
    endfunction

    assign load      = r_act && (!r_ovalid || i_ready);
    assign last_item = (r_sub == S_STAT) || (r_sub == S_CHAR && !r_cmd.fin);
    assign o_q_pop   = i_q_not_empty && (!r_act || (load && last_item));

    // Current result item and the step after it.
    always_comb begin
        cur_comp   = r_cmd.comp;
        cur_sym    = r_cmd.sym;
        cur_has    = 1'b1;
        cur_status = hut_pkg::ST_OK;
        cur_final  = 1'b0;
        n_sub      = r_sub;
        n_idx      = r_idx;
        unique case (r_sub)
            S_CHAR: begin
                n_sub = fin_start(r_cmd);
                n_idx = '0;
            end
            S_PORT: begin
                cur_comp = hut_pkg::COMP_PORT;
                cur_sym  = hut_pkg::port_digit(r_cmd.port_kind, r_idx[1:0]);
                if ((r_cmd.port_kind == hut_pkg::PK_443 && r_idx == 4'd2)
                    || (r_cmd.port_kind != hut_pkg::PK_443 && r_idx == 4'd1)) begin
                    n_sub = r_cmd.path_default ? S_PATH : S_STAT;
                    n_idx = '0;
                end else begin
                    n_idx = r_idx + 4'd1;
                end
            end
            S_PATH: begin
                cur_comp = hut_pkg::COMP_PATH;
                cur_sym  = hut_pkg::path_char(r_idx);
                if (r_idx == hut_pkg::PATH_LAST) begin
                    n_sub = S_STAT;
                    n_idx = '0;
                end else begin
                    n_idx = r_idx + 4'd1;
                end
            end
            S_STAT: begin
                cur_comp   = hut_pkg::COMP_STATUS;
                cur_sym    = '0;
                cur_has    = 1'b0;
                cur_status = r_cmd.status;
                cur_final  = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Command register and sequencing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_sub <= S_CHAR;
            r_idx <= '0;
        end else if (o_q_pop) begin
            r_act <= 1'b1;
            r_sub <= cmd_start(i_q_cmd);
            r_idx <= '0;
        end else if (load) begin
            if (last_item) begin
                r_act <= 1'b0;
            end
            r_sub <= n_sub;
            r_idx <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd <= i_q_cmd;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (load) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            o_component  <= cur_comp;
            o_out_symbol <= cur_sym;
            o_has_symbol <= cur_has;
            o_status     <= cur_status;
            o_final_item <= cur_final;
        end
    end

    assign o_valid = r_ovalid;

endmodule

`default_nettype wire

// ===== design/http_url_tokenizer.sv =====
// A result passes the queue entry, the command register and the output register
// after its character is accepted. Throughput: one character per cycle while each
// yields at most one result and nothing stalls; the back sequencer emits one result per
// cycle unless stalled, and the 4-entry command queue absorbs a URL close with defaults.
// Reset: synchronous, active low; clears phase, flags, queue and output valid.
// ----------------------------------------------------------------------------
// http_url_tokenizer: streaming http/https URL tokenizer
// Front classifier, command queue and back result sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module http_url_tokenizer (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_symbol_in,
    input  wire logic       i_end_of_url,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [2:0]      o_component,
    output logic [7:0]      o_out_symbol,
    output logic            o_has_symbol,
    output logic [2:0]      o_status,
    output logic            o_final_item
);

    logic          q_not_full;
    logic          q_not_empty;
    logic          push;
    logic          pop;
    hut_pkg::t_cmd push_cmd;
    hut_pkg::t_cmd head_cmd;

    // Classify characters into commands.
    hut_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_symbol_in  (i_symbol_in),
        .i_end_of_url (i_end_of_url),
        .i_q_ready    (q_not_full),
        .o_push       (push),
        .o_cmd        (push_cmd)
    );

    // Decouple the two sides.
    hut_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_cmd       (push_cmd),
        .o_not_full  (q_not_full),
        .i_pop       (pop),
        .o_not_empty (q_not_empty),
        .o_cmd       (head_cmd)
    );

    // Expand commands into result transactions.
    hut_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_not_empty (q_not_empty),
        .i_q_cmd       (head_cmd),
        .o_q_pop       (pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_component   (o_component),
        .o_out_symbol  (o_out_symbol),
        .o_has_symbol  (o_has_symbol),
        .o_status      (o_status),
        .o_final_item  (o_final_item)
    );

endmodule

`default_nettype wire

// ===== design/hut_checker.sv =====
// ----------------------------------------------------------------------------
// hut_checker: port-level checks of the URL tokenizer
// Watches both channels for stable stalls and the result channel for
// consistent status items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hut_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       o_ready,
    input wire logic [7:0] i_symbol_in,
    input wire logic       i_end_of_url,
    input wire logic       o_valid,
    input wire logic       i_ready,
    input wire logic [2:0] o_component,
    input wire logic [7:0] o_out_symbol,
    input wire logic       o_has_symbol,
    input wire logic [2:0] o_status,
    input wire logic       o_final_item
);

    // A waiting input transaction keeps its payload.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid && $stable(i_symbol_in) && $stable(i_end_of_url))
        else $error("input changed while waiting");

    // A stalled result transaction holds its component, symbol, status and final flag.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_component)
            && $stable(o_out_symbol) && $stable(o_status) && $stable(o_final_item))
        else $error("result changed while stalled");

    // The closing item is a status item without a character.
    a_final_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_final_item |-> !o_has_symbol
            && o_component == hut_pkg::COMP_STATUS)
        else $error("closing item malformed");

    // Character items carry no status.
    a_char_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_has_symbol |-> o_status == hut_pkg::ST_OK && !o_final_item
            && o_component != hut_pkg::COMP_STATUS)
        else $error("character item carries status");

    // Nothing is offered right after reset.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind http_url_tokenizer hut_checker u_hut_checker (.*);

`default_nettype wire
